[src/button_event_qualifier_top_defines.svh]
// Assertion macros shared by the button event qualifier RTL.
`ifndef BUTTON_EVENT_QUALIFIER_TOP_DEFINES_SVH
`define BUTTON_EVENT_QUALIFIER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked property that is not checked while reset is asserted.
`define BQE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// Clocked property that is checked during reset as well.
`define BQE_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define BQE_ASSERT(label, clk, rst_n, prop)
`define BQE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/bqe_pkg.sv]
package bqe_pkg;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_INVERT_MASK  = 3'd0;
	localparam logic [2:0] REG_SINGLE_MASK  = 3'd1;
	localparam logic [2:0] REG_TIMED_MASK   = 3'd2;
	localparam logic [2:0] REG_COUNT_THRESH = 3'd3;
	localparam logic [2:0] REG_PRESS_LIMIT  = 3'd4;

	localparam logic [31:0] PRESS_LIMIT_RESET = 32'd500000;

	// Stream payload widths.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// What one qualified request turns into on the output.
	typedef enum logic [1:0] {
		KIND_DOWN  = 2'd0,
		KIND_UP    = 2'd1,
		KIND_CLICK = 2'd2
	} ev_kind_t;

	typedef struct packed {
		logic [4:0] button;
		ev_kind_t   kind;
	} ev_t;

	typedef struct packed {
		logic [31:0] invert_mask;
		logic [31:0] single_shot_mask;
		logic [31:0] timed_mask;
		logic [7:0]  count_threshold;
		logic [31:0] short_press_limit_us;
	} cfg_t;

endpackage

[src/bqe_fifo.sv]
`include "button_event_qualifier_top_defines.svh"

module bqe_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bqe_pkg::ev_t  push_ev,
	output logic          full,
	input  logic          pop,
	output bqe_pkg::ev_t  head_ev,
	output logic          empty
);
	import bqe_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	ev_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign head_ev = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BQE_ASSERT(a_no_push_when_full, clk, arst_n, !(push && full))
	`BQE_ASSERT(a_no_pop_when_empty, clk, arst_n, !(pop && empty))

endmodule

[src/bqe_front.sv]
module bqe_front #(
	parameter int BUTTONS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bqe_pkg::cfg_t                 cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bqe_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          ev_push,
	output bqe_pkg::ev_t                  ev,
	input  logic                          ev_full
);
	import bqe_pkg::*;

	localparam int         IDX_W     = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam logic [5:0] BUTTONS_V = 6'(BUTTONS);

	logic        valid_s1;
	logic [4:0]  button_s1;
	logic        pin_s1;
	logic [31:0] now_s1;

	logic [7:0]  counts_q [BUTTONS];
	logic [31:0] stamps_q [BUTTONS];

	logic [IDX_W-1:0] idx;
	logic        in_range;
	logic        inv, single, timed, pressed, reached, short_press;
	logic [31:0] elapsed;
	logic        has_ev, clear_all, inc_count, store_stamp, consume;
	ev_kind_t    kind;

	assign idx      = button_s1[IDX_W-1:0];
	assign in_range = ({1'b0, button_s1} < BUTTONS_V);
	assign inv      = cfg.invert_mask[button_s1];
	assign single   = cfg.single_shot_mask[button_s1];
	assign timed    = cfg.timed_mask[button_s1];
	assign pressed  = pin_s1 ^ inv;
	assign reached  = (counts_q[idx] >= cfg.count_threshold);
	assign elapsed  = now_s1 - stamps_q[idx];
	assign short_press = (elapsed < cfg.short_press_limit_us);

	// Classify the held request into at most one queue entry plus state updates.
	always_comb begin
		has_ev      = 1'b0;
		kind        = KIND_DOWN;
		clear_all   = 1'b0;
		inc_count   = 1'b0;
		store_stamp = 1'b0;
		if (valid_s1 && in_range) begin
			if (!timed) begin
				if (pressed) begin
					if (reached) begin
						has_ev    = 1'b1;
						kind      = single ? KIND_CLICK : KIND_DOWN;
						clear_all = single;
					end
				end else if (reached) begin
					if (!single) begin
						has_ev    = 1'b1;
						kind      = KIND_UP;
						clear_all = 1'b1;
					end
				end else begin
					inc_count = 1'b1;
				end
			end else begin
				if (pressed) begin
					store_stamp = 1'b1;
				end else if (short_press) begin
					has_ev    = 1'b1;
					kind      = KIND_CLICK;
					clear_all = 1'b1;
				end
			end
		end
	end

	assign consume   = valid_s1 && (!has_ev || !ev_full);
	assign s_tready  = !valid_s1 || consume;
	assign ev_push   = consume && has_ev;
	assign ev.button = button_s1;
	assign ev.kind   = kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			button_s1 <= s_tdata[4:0];
			pin_s1    <= s_tdata[5];
			now_s1    <= s_tdata[37:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				counts_q[i] <= '0;
				stamps_q[i] <= '0;
			end
		end else if (consume) begin
			if (clear_all) begin
				for (int i = 0; i < BUTTONS; i++) begin
					counts_q[i] <= '0;
				end
			end else if (inc_count) begin
				counts_q[idx] <= counts_q[idx] + 8'd1;
			end
			if (store_stamp) begin
				stamps_q[idx] <= now_s1;
			end
		end
	end

endmodule

[src/bqe_back.sv]
`include "button_event_qualifier_top_defines.svh"

module bqe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ev_empty,
	input  bqe_pkg::ev_t                  ev,
	output logic                          ev_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bqe_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import bqe_pkg::*;

	logic       valid_q;
	logic       phase_q;
	logic [4:0] key_index_q;
	logic       key_down_q;
	logic       last_q;
	logic       load;

	assign load   = !valid_q || m_tready;
	assign ev_pop = load && !phase_q && !ev_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			if (phase_q) begin
				valid_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (!ev_empty) begin
				valid_q <= 1'b1;
				phase_q <= (ev.kind == KIND_CLICK);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				key_down_q <= 1'b0;
				last_q     <= 1'b1;
			end else if (!ev_empty) begin
				key_index_q <= ev.button;
				case (ev.kind)
					KIND_DOWN: begin
						key_down_q <= 1'b1;
						last_q     <= 1'b1;
					end
					KIND_UP: begin
						key_down_q <= 1'b0;
						last_q     <= 1'b1;
					end
					KIND_CLICK: begin
						key_down_q <= 1'b1;
						last_q     <= 1'b0;
					end
					default: begin
						key_down_q <= 1'b0;
						last_q     <= 1'b1;
					end
				endcase
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, key_down_q, key_index_q};
	assign m_tlast  = last_q;

	// While the key-up of a click is pending, the key-down must be on show.
	`BQE_ASSERT(a_click_first_half, clk, arst_n,
		phase_q |-> (valid_q && key_down_q && !last_q))

endmodule

[src/button_event_qualifier_top.sv]
// Button event qualifier. Each request on the s_ stream is one pin edge of one
// button (index, raw level after the edge, microsecond timestamp). The level is
// mapped to pressed or released through invert_mask, then the button is handled
// in count mode (key events only once its release count reaches count_threshold;
// single-shot buttons report down and up together on the press) or, when its
// timed_mask bit is set, in timed mode (a release within short_press_limit_us of
// the stored press time reports down then up). Every report clears all release
// counts except a non-single-shot key-down. Results leave on the m_ stream; tlast
// marks the final result of an edge. Edges on indexes at or above BUTTONS are
// dropped. The front stage takes one edge per cycle unless the queue stalls it,
// and classifies it against the per-button count and timestamp registers; a
// two-entry queue feeds the output stage, which shows one result per cycle while
// m_tready is high. A click's two results pass the single output register in
// turn, so edges with one or no result sustain one edge per cycle. The user must
// write registers over APB only while the block is idle; this is not enforced.
module button_event_qualifier_top #(
	parameter int BUTTONS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input edge requests. s_tdata: [4:0] button, [5] pin_level, [37:6] now_us,
	// [39:38] zero.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// Key events. m_tdata: [4:0] key_index, [5] key_down, [7:6] zero.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bqe_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	logic ev_push, ev_full, ev_pop, ev_empty;
	ev_t  ev_in, ev_head;

	// Register file. The register index is the word address; the two low
	// address bits are ignored.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_mask          <= '0;
			cfg_q.single_shot_mask     <= '0;
			cfg_q.timed_mask           <= '0;
			cfg_q.count_threshold      <= '0;
			cfg_q.short_press_limit_us <= PRESS_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INVERT_MASK:  cfg_q.invert_mask          <= pwdata;
				REG_SINGLE_MASK:  cfg_q.single_shot_mask     <= pwdata;
				REG_TIMED_MASK:   cfg_q.timed_mask           <= pwdata;
				REG_COUNT_THRESH: cfg_q.count_threshold      <= pwdata[7:0];
				REG_PRESS_LIMIT:  cfg_q.short_press_limit_us <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INVERT_MASK:  prdata = cfg_q.invert_mask;
			REG_SINGLE_MASK:  prdata = cfg_q.single_shot_mask;
			REG_TIMED_MASK:   prdata = cfg_q.timed_mask;
			REG_COUNT_THRESH: prdata = {24'd0, cfg_q.count_threshold};
			REG_PRESS_LIMIT:  prdata = cfg_q.short_press_limit_us;
			default:          prdata = '0;
		endcase
	end

	// Front: holds one edge, qualifies it and updates the per-button state.
	bqe_front #(
		.BUTTONS(BUTTONS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.ev_push (ev_push),
		.ev      (ev_in),
		.ev_full (ev_full)
	);

	// Queue of qualified events between the two halves.
	bqe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.push_ev(ev_in),
		.full   (ev_full),
		.pop    (ev_pop),
		.head_ev(ev_head),
		.empty  (ev_empty)
	);

	// Back: expands each event into one or two key results.
	bqe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ev_empty(ev_empty),
		.ev      (ev_head),
		.ev_pop  (ev_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[tb/button_event_qualifier_top_tb.sv]
module button_event_qualifier_top_tb;
	import bqe_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [2:0] REG_UNMAPPED = 3'd5;
	localparam logic KEY_PRESS = 1'b1;
	localparam logic KEY_RELEASE = 1'b0;

	typedef struct packed {
		logic [4:0]  button;
		logic        pin;
		logic [31:0] now_us;
	} pin_edge_t;

	typedef struct packed {
		logic [4:0] key_index;
		logic       key_down;
		logic       last;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	button_event_qualifier_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// Our own copy of the register file, mirrored at every APB write.
	logic [31:0] cfg_invert;
	logic [31:0] cfg_single;
	logic [31:0] cfg_timed;
	logic [7:0]  cfg_threshold;
	logic [31:0] cfg_limit;

	// Per-button qualifier state, the same as the block keeps.
	logic [7:0]  rel_count [32];
	logic [31:0] stamp_us [32];

	// Edge requests waiting to be driven and key events waiting to arrive.
	pin_edge_t   edge_q [$];
	key_event_t  key_q [$];
	pin_edge_t   cur_edge;

	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_events = 0;
	int unsigned n_writes = 0;
	int unsigned n_bad = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned src_gap = 0;
	int unsigned snk_stall = 0;
	int unsigned quiet = 0;
	logic [31:0] clock_us;

	initial begin
		cfg_invert = '0;
		cfg_single = '0;
		cfg_timed = '0;
		cfg_threshold = '0;
		cfg_limit = PRESS_LIMIT_RESET;
		foreach (rel_count[i]) begin
			rel_count[i] = '0;
			stamp_us[i] = '0;
		end
	end

	// Only the first few mismatches are worth reading; the rest are counted.
	function automatic void flag_mismatch(input string what);
		n_bad++;
		if (n_bad <= 10) begin
			$display("MISMATCH: %s", what);
		end
	endfunction

	function automatic void clear_rel_counts();
		foreach (rel_count[i]) begin
			rel_count[i] = '0;
		end
	endfunction

	function automatic void expect_key(input logic [4:0] idx, input logic down,
			input logic is_last);
		key_event_t ev;
		ev.key_index = idx;
		ev.key_down = down;
		ev.last = is_last;
		key_q.push_back(ev);
	endfunction

	// Works out the key events that one accepted edge request causes and
	// advances the per-button state the same way the block does.
	function automatic void qualify_edge(input pin_edge_t r);
		logic        single;
		logic        pressed;
		logic        reached;
		logic [31:0] held;
		single = cfg_single[r.button];
		pressed = r.pin ^ cfg_invert[r.button];
		if (!cfg_timed[r.button]) begin
			reached = rel_count[r.button] >= cfg_threshold;
			if (pressed) begin
				if (reached) begin
					expect_key(r.button, KEY_PRESS, !single);
					if (single) begin
						expect_key(r.button, KEY_RELEASE, 1'b1);
						clear_rel_counts();
					end
				end
			end else if (reached) begin
				if (!single) begin
					expect_key(r.button, KEY_RELEASE, 1'b1);
					clear_rel_counts();
				end
			end else begin
				rel_count[r.button] = rel_count[r.button] + 8'd1;
			end
		end else if (pressed) begin
			stamp_us[r.button] = r.now_us;
		end else begin
			// The press duration wraps modulo 2^32 along with the timestamp.
			held = r.now_us - stamp_us[r.button];
			if (held < cfg_limit) begin
				expect_key(r.button, KEY_PRESS, 1'b0);
				expect_key(r.button, KEY_RELEASE, 1'b1);
				clear_rel_counts();
			end
		end
	endfunction

	// Source side. A request stays on the bus until it is taken; after a
	// request is loaded, a random burst of idle cycles may follow it.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				qualify_edge(cur_edge);
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (edge_q.size() != 0) begin
					cur_edge = edge_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_edge.now_us, cur_edge.pin, cur_edge.button};
					if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
						src_gap = $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side. Back-pressure comes in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_stall = 0;
		end else if (snk_stall > 0) begin
			snk_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				snk_stall = $urandom_range(1, 5);
			end
		end
	end

	// Every key event taken from the block is checked against the oldest
	// outstanding expectation, field by field.
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_events++;
			if (key_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected key event key_index=%0d key_down=%0b last=%0b",
					m_tdata[4:0], m_tdata[5], m_tlast));
			end else begin
				want = key_q.pop_front();
				if (m_tdata[4:0] !== want.key_index || m_tdata[5] !== want.key_down ||
						m_tlast !== want.last) begin
					flag_mismatch($sformatf(
						"key event: expected key_index=%0d key_down=%0b last=%0b, got %0d %0b %0b",
						want.key_index, want.key_down, want.last,
						m_tdata[4:0], m_tdata[5], m_tlast));
				end
			end
		end
	end

	// Watchdog: a long run of cycles in which no handshake of any kind
	// completes means the block has hung or lost a result.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet == QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d key events still due",
					QUIET_LIMIT, key_q.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic put_edge(input logic [4:0] b, input logic pin, input logic [31:0] now);
		pin_edge_t r;
		r.button = b;
		r.pin = pin;
		r.now_us = now;
		edge_q.push_back(r);
		n_queued++;
	endtask

	// Waits until every request has been taken and every key event has
	// arrived, then lets the pipeline drain before registers may change.
	task automatic settle();
		while (!(n_accepted == n_queued && key_q.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB write (setup then access), followed by a read-back of the
	// same register when it is a mapped one.
	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_writes++;
		case (idx)
			REG_INVERT_MASK: cfg_invert = val;
			REG_SINGLE_MASK: cfg_single = val;
			REG_TIMED_MASK: cfg_timed = val;
			REG_COUNT_THRESH: cfg_threshold = val[7:0];
			REG_PRESS_LIMIT: cfg_limit = val;
			default: ;
		endcase
		if (idx <= REG_PRESS_LIMIT) begin
			case (idx)
				REG_INVERT_MASK: want = cfg_invert;
				REG_SINGLE_MASK: want = cfg_single;
				REG_TIMED_MASK: want = cfg_timed;
				REG_COUNT_THRESH: want = {24'd0, cfg_threshold};
				default: want = cfg_limit;
			endcase
			@(posedge clk);
			psel <= 1'b1;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			if (prdata !== want) begin
				flag_mismatch($sformatf("register %0d read back: expected %h, got %h",
					idx, want, prdata));
			end
		end
	endtask

	task automatic load_setup(input logic [31:0] inv, input logic [31:0] single,
			input logic [31:0] timed, input logic [7:0] thr, input logic [31:0] lim);
		set_reg(REG_INVERT_MASK, inv);
		set_reg(REG_SINGLE_MASK, single);
		set_reg(REG_TIMED_MASK, timed);
		set_reg(REG_COUNT_THRESH, {24'd0, thr});
		set_reg(REG_PRESS_LIMIT, lim);
	endtask

	// Random traffic. Unless rel_pct is large, most of it is press/release pairs
	// whose press duration sits on, just around or far from the short-press limit;
	// some of it is lone releases that build up release counts, and the rest is
	// noise with fully random fields.
	task automatic queue_mix(input int n, input int lo, input int hi, input int rel_pct);
		int          made;
		int unsigned roll;
		logic [4:0]  b;
		logic [31:0] held;
		made = 0;
		while (made < n) begin
			roll = $urandom_range(0, 99);
			b = 5'($urandom_range(lo, hi));
			clock_us = clock_us + $urandom_range(1, 5000);
			if (roll < 12) begin
				put_edge(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), $urandom);
				made++;
			end else if (roll < 12 + rel_pct) begin
				put_edge(b, cfg_invert[b], clock_us);
				made++;
			end else begin
				case ($urandom_range(0, 5))
					0: held = 32'd0;
					1: held = cfg_limit - 32'd1;
					2: held = cfg_limit;
					3: held = cfg_limit + 32'd1;
					4: held = $urandom_range(0, 2000);
					default: held = $urandom;
				endcase
				put_edge(b, ~cfg_invert[b], clock_us);
				clock_us = clock_us + held;
				put_edge(b, cfg_invert[b], clock_us);
				made += 2;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		clock_us = $urandom;
		src_idle_pct = 30;
		snk_idle_pct = 30;

		// Reset values: count mode with threshold zero, so every press and
		// every release is reported at once, here at the extreme buttons
		// and timestamps.
		put_edge(5'd0, 1'b1, 32'd0);
		put_edge(5'd0, 1'b0, 32'd1);
		put_edge(5'd31, 1'b1, 32'hFFFF_FFFF);
		put_edge(5'd31, 1'b0, 32'hFFFF_FFFF);
		settle();

		// Timed buttons 5 and 31. The first release on button 5 has never
		// seen a press, so it is measured against the reset stamp of zero.
		// Then a click across the timestamp wrap, a press held exactly the
		// limit (no click) and one held one microsecond less (click).
		load_setup(32'd0, 32'd0, 32'h8000_0020, 8'd0, PRESS_LIMIT_RESET);
		put_edge(5'd5, 1'b0, 32'd100);
		put_edge(5'd5, 1'b1, 32'hFFFF_FFF0);
		put_edge(5'd5, 1'b0, 32'h0000_0010);
		put_edge(5'd31, 1'b1, 32'd0);
		put_edge(5'd31, 1'b0, 32'd500000);
		put_edge(5'd31, 1'b1, 32'd7);
		put_edge(5'd31, 1'b0, 32'd500006);
		settle();

		// A zero limit: not even a zero-length press qualifies.
		set_reg(REG_PRESS_LIMIT, 32'd0);
		put_edge(5'd5, 1'b1, 32'd3);
		put_edge(5'd5, 1'b0, 32'd3);
		settle();

		// Count mode with threshold two. Button 2 is inverted and single
		// shot: its press reports down and up together, and its release at
		// the threshold reports nothing. Button 7 reports up on its third
		// release, and the report leaves its press below the threshold.
		load_setup(32'h4, 32'h4, 32'd0, 8'd2, PRESS_LIMIT_RESET);
		put_edge(5'd2, 1'b1, 32'd10);
		put_edge(5'd2, 1'b1, 32'd20);
		put_edge(5'd2, 1'b0, 32'd30);
		put_edge(5'd2, 1'b1, 32'd40);
		put_edge(5'd7, 1'b0, 32'd50);
		put_edge(5'd7, 1'b0, 32'd60);
		put_edge(5'd7, 1'b0, 32'd70);
		put_edge(5'd7, 1'b1, 32'd80);
		put_edge(5'd2, 1'b1, 32'd90);
		put_edge(5'd2, 1'b1, 32'd100);
		put_edge(5'd2, 1'b1, 32'd110);
		settle();

		// Everything random, small thresholds so that reports are common.
		load_setup($urandom, $urandom, $urandom, 8'($urandom_range(0, 3)),
			$urandom_range(1, 20000));
		queue_mix(300, 0, 31, 20);
		settle();

		// All buttons inverted and single shot, with no idling on either side.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, PRESS_LIMIT_RESET);
		queue_mix(100, 0, 31, 20);
		settle();

		// All timed with a zero limit: nothing may come out.
		src_idle_pct = 40;
		snk_idle_pct = 40;
		load_setup(32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0, 32'd0);
		queue_mix(60, 0, 31, 10);
		settle();

		// All timed with the largest limit.
		src_idle_pct = 25;
		snk_idle_pct = 25;
		load_setup($urandom, $urandom, 32'hFFFF_FFFF, 8'($urandom), 32'hFFFF_FFFF);
		queue_mix(150, 0, 31, 15);
		settle();

		// Largest threshold: a long run of releases on one button has to
		// climb the whole count before anything is reported.
		src_idle_pct = 20;
		snk_idle_pct = 20;
		load_setup($urandom, 32'd0, 32'd0, 8'd255, $urandom);
		queue_mix(300, 4, 4, 90);
		settle();

		// Smallest nonzero limit: only a zero-length timed press is a click.
		src_idle_pct = 30;
		snk_idle_pct = 30;
		load_setup($urandom, $urandom, $urandom, 8'd1, 32'd1);
		queue_mix(120, 0, 31, 20);
		settle();

		// Final stretch without idling. A write to an unmapped address must
		// leave the register file alone.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_setup($urandom, $urandom, $urandom, 8'($urandom_range(0, 4)),
			$urandom_range(1, 100000));
		set_reg(REG_UNMAPPED, $urandom);
		queue_mix(250, 0, 31, 20);
		settle();

		$display("Drove %0d edge requests and checked %0d key events over %0d register writes,",
			n_accepted, n_events, n_writes);
		$display("covering count, single-shot and timed buttons at extreme thresholds and limits.");
		if (n_bad == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
